@@ rtl/core/tkf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt Kalman filter package
// Widths, register indexes, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tkf_pkg;

  localparam int ELAPSED_W = 20;
  localparam int RATE_W    = 16;
  localparam int ACCEL_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int VAR_W     = 24;
  localparam int EST_VAR_W = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_VAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VAR = 2'd1;

  localparam logic [VAR_W-1:0] GYRO_VAR_RST = 24'd655;
  localparam logic [VAR_W-1:0] MEAS_VAR_RST = 24'd65536;

  localparam int USEC_PER_S = 1000000;
  localparam int HALF_USEC  = 500000;

  // Division by one million: the numerator drops its low RCP_SHIFT bits and is
  // multiplied by floor(2^45 / 10^6); the estimate is short by at most two.
  localparam int          CDIV_NUM_W = 45;
  localparam int          CDIV_QUO_W = 25;
  localparam int          RCP_SHIFT  = 13;
  localparam logic [25:0] USEC_RCP   = 26'd35184372;

  localparam int DIV_NUM_W = 49;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = 6;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;
  localparam int ATAN_IDX_W       = 5;
  localparam int CORDIC_W         = 34;
  localparam int CORDIC_PRESHIFT  = 14;

  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255, 32'd127
  };

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

@@ rtl/core/tkf_in_if.sv @@
// ----------------------------------------------------------------------------
// Sample channel
// Carries one sensor sample request: elapsed time, gyro rate and two axes.
// ----------------------------------------------------------------------------
interface tkf_in_if;
  logic                                valid;
  logic                                ready;
  logic        [tkf_pkg::ELAPSED_W-1:0] elapsed_us;
  logic signed [tkf_pkg::RATE_W-1:0]    gyro_rate;
  logic signed [tkf_pkg::ACCEL_W-1:0]   accel_y;
  logic signed [tkf_pkg::ACCEL_W-1:0]   accel_z;

  modport source (output valid, elapsed_us, gyro_rate, accel_y, accel_z, input ready);
  modport sink (input valid, elapsed_us, gyro_rate, accel_y, accel_z, output ready);
endinterface

@@ rtl/core/tkf_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Carries the filtered tilt angle and the control rate.
// ----------------------------------------------------------------------------
interface tkf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tkf_pkg::ANGLE_W-1:0] tilt_angle;
  logic signed [tkf_pkg::RATE_W-1:0]  tilt_rate;

  modport source (output valid, tilt_angle, tilt_rate, input ready);
  modport sink (input valid, tilt_angle, tilt_rate, output ready);
endinterface

@@ rtl/core/tkf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data.
// ----------------------------------------------------------------------------
interface tkf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tkf_pkg::CFG_IDX_W-1:0]     index;
  logic [tkf_pkg::VAR_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tilt_angle_kalman_filter.sv @@
// The result of an accepted request waits for the gain division; the CORDIC and
// both reciprocal divisions by one million finish before it. With a zero gain
// denominator the division is skipped and the result waits only for the CORDIC.
// A new request is taken only once the previous one has reached the output register;
// it is taken while that result waits there, and an untaken result stalls the next one.
// Reset: estimate and variance clear to zero, registers take their defaults.
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter
// Scalar Kalman filter fusing a gyro rate with an accelerometer tilt angle.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter #(
  parameter int CORDIC_STEPS = tkf_pkg::CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tkf_in_if.sink    in_i,
  tkf_out_if.source out_o,
  tkf_cfg_if.sink   cfg_i
);
  import tkf_pkg::*;

  localparam int ST_W = 4;
  localparam int PROD_W = 61;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_MUL_DT  = 4'd1;
  localparam logic [ST_W-1:0] S_ST_DT   = 4'd2;
  localparam logic [ST_W-1:0] S_RCP_DT  = 4'd3;
  localparam logic [ST_W-1:0] S_FIX_DT  = 4'd4;
  localparam logic [ST_W-1:0] S_MUL_GV  = 4'd5;
  localparam logic [ST_W-1:0] S_ST_GV   = 4'd6;
  localparam logic [ST_W-1:0] S_RCP_GV  = 4'd7;
  localparam logic [ST_W-1:0] S_FIX_GV  = 4'd8;
  localparam logic [ST_W-1:0] S_ST_K    = 4'd9;
  localparam logic [ST_W-1:0] S_DIV_K   = 4'd10;
  localparam logic [ST_W-1:0] S_WAIT_Z  = 4'd11;
  localparam logic [ST_W-1:0] S_MUL_COR = 4'd12;
  localparam logic [ST_W-1:0] S_COR     = 4'd13;
  localparam logic [ST_W-1:0] S_MUL_VAR = 4'd14;
  localparam logic [ST_W-1:0] S_DONE    = 4'd15;

  logic [ST_W-1:0]            state_q, state_d;
  logic [VAR_W-1:0]           gv_q, mv_q;
  logic [ELAPSED_W-1:0]       el_q;
  logic signed [RATE_W-1:0]   u_q, u_in;
  logic signed [ANGLE_W-1:0]  est_q, xnew_q, out_angle_q, z;
  logic [EST_VAR_W-1:0]       p_q, p_pred_q, p_new;
  logic signed [19:0]         x_pred_q;
  logic [16:0]                k_q;
  logic                       dt_neg_q;
  logic                       out_valid_q;
  logic signed [RATE_W-1:0]   out_rate_q;
  logic signed [CORDIC_W-1:0] mul_a;
  logic signed [26:0]         mul_b;
  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_en;
  logic [PROD_W-1:0]          prod_mag;
  logic [PROD_W-1:0]          var_rnd;
  logic [DIV_DEN_W-1:0]       s_sum;
  logic [DIV_DEN_W-1:0]       p_sum;
  logic signed [20:0]         diff;
  logic [PROD_W-1:0]          cor_rnd;
  logic signed [22:0]         cor_s, x_sum;
  logic signed [19:0]         dtu;
  logic [CDIV_NUM_W-1:0]      cdiv_num, cdiv_num_q, cdiv_rem;
  logic [CDIV_QUO_W-1:0]      cq0_q, cdiv_quo;
  logic                       div_start;
  logic [DIV_NUM_W-1:0]       div_num, div_quo;
  logic [DIV_DEN_W-1:0]       div_den;
  unit_status_t               div_st, cor_st;
  logic                       in_acc, out_free;
  logic signed [ACCEL_W:0]    neg_ay;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign u_in     = (in_i.gyro_rate == -16'sh8000) ? 16'sh7FFF : -in_i.gyro_rate;
  assign neg_ay   = -(ACCEL_W+1)'(in_i.accel_y);

  tkf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .y_i     (neg_ay),
    .x_i     (in_i.accel_z),
    .angle_o (z),
    .status_o(cor_st)
  );

  tkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .status_o(div_st)
  );

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b1;
    diff    = 21'(z) - 21'(x_pred_q);
    unique case (state_q)
      S_MUL_DT: begin
        mul_a = CORDIC_W'(el_q);
        mul_b = 27'(u_q);
      end
      S_MUL_GV: begin
        mul_a = CORDIC_W'(el_q);
        mul_b = $signed({3'b0, gv_q});
      end
      S_ST_DT, S_ST_GV: begin
        mul_a = $signed({2'b0, cdiv_num[CDIV_NUM_W-1:RCP_SHIFT]});
        mul_b = $signed({1'b0, USEC_RCP});
      end
      S_RCP_DT, S_RCP_GV: begin
        mul_a = $signed({9'b0, prod_q[56:32]});
        mul_b = 27'(USEC_PER_S);
      end
      S_MUL_COR: begin
        mul_a = CORDIC_W'(diff);
        mul_b = $signed({10'b0, k_q});
      end
      S_MUL_VAR: begin
        mul_a = $signed({2'b0, p_pred_q});
        mul_b = $signed({10'b0, 17'(17'd65536 - k_q)});
      end
      default: prod_en = 1'b0;
    endcase
  end

  always_comb begin
    prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    cdiv_num = (state_q == S_ST_DT)
             ? CDIV_NUM_W'({prod_mag[42:0], 2'b00}) + CDIV_NUM_W'(HALF_USEC)
             : CDIV_NUM_W'(prod_q[43:0]) + CDIV_NUM_W'(HALF_USEC);
    cdiv_rem = cdiv_num_q - prod_q[CDIV_NUM_W-1:0];
    cdiv_quo = cq0_q + ((cdiv_rem >= CDIV_NUM_W'(2 * USEC_PER_S)) ? CDIV_QUO_W'(2) :
                        (cdiv_rem >= CDIV_NUM_W'(USEC_PER_S))     ? CDIV_QUO_W'(1) :
                                                                    CDIV_QUO_W'(0));
    s_sum    = {1'b0, p_pred_q} + DIV_DEN_W'(mv_q);
    p_sum    = {1'b0, p_q} + DIV_DEN_W'(cdiv_quo);
    dtu      = dt_neg_q ? -$signed({2'b0, cdiv_quo[17:0]}) : $signed({2'b0, cdiv_quo[17:0]});
    cor_rnd  = prod_mag + PROD_W'(32768);
    cor_s    = prod_q[PROD_W-1] ? -$signed({1'b0, cor_rnd[37:16]})
                                : $signed({1'b0, cor_rnd[37:16]});
    x_sum    = 23'(x_pred_q) + cor_s;
    var_rnd  = PROD_W'(prod_q) + PROD_W'(32768);
    p_new    = var_rnd[47:16];
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state_q == S_ST_K) begin
      div_start = s_sum != '0;
      div_num   = DIV_NUM_W'({p_pred_q, 16'b0}) + DIV_NUM_W'(s_sum[DIV_DEN_W-1:1]);
      div_den   = s_sum;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = S_MUL_DT;
      S_MUL_DT:  state_d = S_ST_DT;
      S_ST_DT:   state_d = S_RCP_DT;
      S_RCP_DT:  state_d = S_FIX_DT;
      S_FIX_DT:  state_d = S_MUL_GV;
      S_MUL_GV:  state_d = S_ST_GV;
      S_ST_GV:   state_d = S_RCP_GV;
      S_RCP_GV:  state_d = S_FIX_GV;
      S_FIX_GV:  state_d = S_ST_K;
      S_ST_K:    state_d = (s_sum != '0) ? S_DIV_K : S_WAIT_Z;
      S_DIV_K:   if (div_st.done) state_d = S_WAIT_Z;
      S_WAIT_Z:  if (!cor_st.busy) state_d = S_MUL_COR;
      S_MUL_COR: state_d = S_COR;
      S_COR:     state_d = S_MUL_VAR;
      S_MUL_VAR: state_d = S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gv_q        <= GYRO_VAR_RST;
      mv_q        <= MEAS_VAR_RST;
      est_q       <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_GYRO_VAR) begin
          gv_q <= cfg_i.data;
        end else if (cfg_i.index == CFG_MEAS_VAR) begin
          mv_q <= cfg_i.data;
        end
      end
      if (state_q == S_DONE && out_free) begin
        est_q       <= xnew_q;
        p_q         <= p_new;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      el_q <= in_i.elapsed_us;
      u_q  <= u_in;
    end
    if (prod_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (state_q == S_ST_DT) begin
      dt_neg_q <= prod_q[PROD_W-1];
    end
    if (state_q == S_ST_DT || state_q == S_ST_GV) begin
      cdiv_num_q <= cdiv_num;
    end
    if (state_q == S_RCP_DT || state_q == S_RCP_GV) begin
      cq0_q <= prod_q[56:32];
    end
    if (state_q == S_FIX_DT) begin
      x_pred_q <= 20'(est_q) + dtu;
    end
    if (state_q == S_FIX_GV) begin
      p_pred_q <= p_sum[DIV_DEN_W-1] ? '1 : p_sum[EST_VAR_W-1:0];
    end
    if (state_q == S_ST_K) begin
      k_q <= '0;
    end else if (state_q == S_DIV_K && div_st.done) begin
      k_q <= div_quo[16:0];
    end
    if (state_q == S_COR) begin
      if (x_sum > 32767) begin
        xnew_q <= 16'sh7FFF;
      end else if (x_sum < -32768) begin
        xnew_q <= -16'sh8000;
      end else begin
        xnew_q <= x_sum[ANGLE_W-1:0];
      end
    end
    if (state_q == S_DONE && out_free) begin
      out_angle_q <= xnew_q;
      out_rate_q  <= u_q;
    end
  end

  assign in_i.ready       = state_q == S_IDLE;
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.tilt_angle = out_angle_q;
  assign out_o.tilt_rate  = out_rate_q;

`ifndef NO_ASSERTIONS
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL_COR |-> k_q <= 17'd65536) else $error("gain above one");
  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> p_new <= p_pred_q) else $error("variance grew in correction");
  a_angle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL_COR |-> !cor_st.busy) else $error("CORDIC angle used early");
`endif

endmodule

@@ rtl/core/tkf_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, used for the Kalman gain quotient.
// ----------------------------------------------------------------------------
module tkf_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tkf_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [tkf_pkg::DIV_DEN_W-1:0]   den_i,
  output logic [tkf_pkg::DIV_NUM_W-1:0]   quo_o,
  output tkf_pkg::unit_status_t           status_o
);
  import tkf_pkg::*;

  logic [DIV_NUM_W-1:0] shf_q, shf_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W:0]   rem_sh, rem_sub;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic                 qbit;

  always_comb begin
    rem_sh  = {rem_q, shf_q[DIV_NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    qbit    = rem_sh >= {1'b0, den_q};
    shf_d   = shf_q;
    den_d   = den_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shf_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(DIV_NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
      shf_d = {shf_q[DIV_NUM_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign quo_o         = shf_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ rtl/core/tkf_cordic.sv @@
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Computes atan2(y, x) in Q3.13, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tkf_cordic #(
  parameter int STEPS = tkf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [tkf_pkg::ACCEL_W:0]    y_i,
  input  logic signed [tkf_pkg::ACCEL_W-1:0]  x_i,
  output logic signed [tkf_pkg::ANGLE_W-1:0]  angle_o,
  output tkf_pkg::unit_status_t               status_o
);
  import tkf_pkg::*;

  // Steps beyond the arctangent table act as the full table.
  localparam int STEPS_USED = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

  logic signed [CORDIC_W-1:0] xs_q, xs_d, ys_q, ys_d, acc_q, acc_d;
  logic signed [CORDIC_W-1:0] xs0, ys0, dx, dy, atan_v, acc_mag;
  logic [ATAN_IDX_W-1:0]      cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [CORDIC_W-1:0]        rnd;
  logic signed [CORDIC_W-17:0] q_s;

  always_comb begin
    xs0    = CORDIC_W'(x_i) <<< CORDIC_PRESHIFT;
    ys0    = CORDIC_W'(y_i) <<< CORDIC_PRESHIFT;
    dx     = ys_q >>> cnt_q;
    dy     = xs_q >>> cnt_q;
    atan_v = CORDIC_W'(ATAN_TAB[cnt_q]);
    xs_d   = xs_q;
    ys_d   = ys_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      if (xs0 < 0) begin
        if (ys0 >= 0) begin
          xs_d  = ys0;
          ys_d  = -xs0;
          acc_d = HALF_PI_Q30;
        end else begin
          xs_d  = -ys0;
          ys_d  = xs0;
          acc_d = -HALF_PI_Q30;
        end
      end else begin
        xs_d  = xs0;
        ys_d  = ys0;
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (ys_q > 0) begin
        xs_d  = xs_q + dx;
        ys_d  = ys_q - dy;
        acc_d = acc_q + atan_v;
      end else if (ys_q < 0) begin
        xs_d  = xs_q - dx;
        ys_d  = ys_q + dy;
        acc_d = acc_q - atan_v;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ATAN_IDX_W'(STEPS_USED - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    acc_mag = (acc_q < 0) ? -acc_q : acc_q;
    rnd     = acc_mag + CORDIC_W'(65536);
    q_s     = (acc_q < 0) ? -$signed({1'b0, rnd[CORDIC_W-1:17]})
                          : $signed({1'b0, rnd[CORDIC_W-1:17]});
    if (q_s > 32767) begin
      angle_o = 16'sh7FFF;
    end else if (q_s < -32768) begin
      angle_o = -16'sh8000;
    end else begin
      angle_o = q_s[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q  <= xs_d;
    ys_q  <= ys_d;
    acc_q <= acc_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ tb/tb_tilt_angle_kalman_filter.sv @@
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter testbench
// Drives sensor samples with random gaps and register writes, predicts each
// filtered angle and control rate in fixed point and checks every result.
// ----------------------------------------------------------------------------
class tilt_scoreboard;
  logic [23:0]        gyro_var;
  logic [23:0]        meas_var;
  logic signed [15:0] angle_est;
  logic [31:0]        est_var;
  logic signed [15:0] angle_q[$];
  logic signed [15:0] rate_q[$];
  int                 errors;

  function new();
    gyro_var  = tkf_pkg::GYRO_VAR_RST;
    meas_var  = tkf_pkg::MEAS_VAR_RST;
    angle_est = 0;
    est_var   = 0;
    errors    = 0;
  endfunction

  function longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function longint fdiv(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function longint tilt_atan2(longint y, longint x, int steps);
    longint xs, ys, acc, t, dx, dy;
    xs  = x * 16384;
    ys  = y * 16384;
    acc = 0;
    if (xs == 0 && ys == 0) return 0;
    if (xs < 0) begin
      t = xs;
      if (ys >= 0) begin
        xs = ys; ys = -t; acc = tkf_pkg::HALF_PI_Q30;
      end else begin
        xs = -ys; ys = t; acc = -longint'(tkf_pkg::HALF_PI_Q30);
      end
    end
    if (steps > tkf_pkg::ATAN_LEN) steps = tkf_pkg::ATAN_LEN;
    for (int i = 0; i < steps; i++) begin
      dx = fdiv(ys, i);
      dy = fdiv(xs, i);
      if (ys > 0) begin
        xs += dx; ys -= dy; acc += tkf_pkg::ATAN_TAB[i];
      end else if (ys < 0) begin
        xs -= dx; ys += dy; acc -= tkf_pkg::ATAN_TAB[i];
      end
    end
    return sat16(round_div(acc, 131072));
  endfunction

  function void write_reg(logic [1:0] idx, logic [23:0] val);
    if (idx == tkf_pkg::CFG_GYRO_VAR) gyro_var = val;
    else if (idx == tkf_pkg::CFG_MEAS_VAR) meas_var = val;
  endfunction

  function void note_sample(logic [19:0] el, logic signed [15:0] gr,
                            logic signed [15:0] ay, logic signed [15:0] az);
    longint u, xp, z, xn;
    longint unsigned pp, s, k;
    u  = sat16(-longint'(gr));
    xp = longint'(angle_est) + round_div(longint'(el) * u * 4, 1000000);
    pp = longint'(est_var) + (longint'(el) * longint'(gyro_var) + 500000) / 1000000;
    if (pp > 64'hFFFFFFFF) pp = 64'hFFFFFFFF;
    z = tilt_atan2(-longint'(ay), longint'(az), tkf_pkg::CORDIC_STEPS_DEF);
    s = pp + meas_var;
    k = 0;
    if (s != 0) k = (pp * 65536 + s / 2) / s;
    xn = sat16(xp + round_div((z - xp) * longint'(k), 65536));
    angle_est = xn;
    est_var   = ((65536 - k) * pp + 32768) >> 16;
    angle_q.push_back(xn);
    rate_q.push_back(u);
  endfunction

  function void check_result(logic signed [15:0] ang, logic signed [15:0] rt);
    logic signed [15:0] ea, er;
    if (angle_q.size() == 0) begin
      $display("%0t: result with none expected: angle %0d rate %0d", $time, ang, rt);
      errors++;
      return;
    end
    ea = angle_q.pop_front();
    er = rate_q.pop_front();
    if (ang !== ea) begin
      $display("%0t: tilt_angle expected %0d actual %0d", $time, ea, ang);
      errors++;
    end
    if (rt !== er) begin
      $display("%0t: tilt_rate expected %0d actual %0d", $time, er, rt);
      errors++;
    end
  endfunction
endclass

module tb_tilt_angle_kalman_filter;
  import tkf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   stall_cycles = 0;
  bit   no_gaps = 0;
  bit   stim_done = 0;

  tkf_in_if  in_if();
  tkf_out_if out_if();
  tkf_cfg_if cfg_if();

  tilt_scoreboard tilt_sb = new();

  tilt_angle_kalman_filter dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.elapsed_us = '0;
    in_if.gyro_rate = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // The request stays valid until the next request or a register write
  // replaces or drops it; after acceptance the block is busy until the result is registered.
  task automatic send_sample(logic [19:0] el, logic signed [15:0] gr,
                             logic signed [15:0] ay, logic signed [15:0] az);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.elapsed_us <= el;
    in_if.gyro_rate <= gr;
    in_if.accel_y <= ay;
    in_if.accel_z <= az;
    do @(posedge clk_i); while (!in_if.ready);
    tilt_sb.note_sample(el, gr, ay, az);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (tilt_sb.angle_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    in_if.valid <= 1'b0;
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    tilt_sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_sample();
    logic [19:0] el;
    logic signed [15:0] gr, ay, az;
    case ($urandom_range(0, 3))
      0: el = $urandom;
      1: el = $urandom_range(0, 20000);
      2: el = $urandom_range(1000, 10000);
      default: el = ($urandom_range(0, 1) != 0) ? 20'hFFFFF : 20'd0;
    endcase
    gr = $urandom;
    ay = $urandom;
    az = $urandom;
    if ($urandom_range(0, 3) == 0) gr = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
    if ($urandom_range(0, 9) == 0) ay = 0;
    if ($urandom_range(0, 9) == 0) az = 0;
    send_sample(el, gr, ay, az);
  endtask

  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) tilt_sb.check_result(out_if.tilt_angle, out_if.tilt_rate);
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || stim_done)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 2000) begin
      $display("tilt_angle_kalman_filter test failed");
      $finish;
    end
  end

  initial begin
    logic [23:0] settings[4];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_sample(20'd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(20'd5000, -16'sd32768, 16'sd0, -16'sd1000);
    send_sample(20'hFFFFF, 16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(20'hFFFFF, -16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(20'd1000, 16'sd100, 16'sd32767, -16'sd32768);
    send_sample(20'd1000, -16'sd100, -16'sd32768, 16'sd0);
    send_sample(20'd1, 16'sd1, 16'sd1, 16'sd1);
    send_sample(20'd4000, 16'sd0, -16'sd5000, 16'sd16000);
    send_sample(20'hAAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_sample(20'h55555, 16'hAAAA, 16'hAAAA, 16'h5555);

    write_reg(CFG_GYRO_VAR, 24'd0);
    write_reg(CFG_MEAS_VAR, 24'd0);
    send_sample(20'd0, 16'sd50, 16'sd0, 16'sd0);
    send_sample(20'd3000, 16'sd50, 16'sd200, 16'sd9000);
    write_reg(CFG_GYRO_VAR, 24'hFFFFFF);
    write_reg(CFG_MEAS_VAR, 24'hFFFFFF);
    send_sample(20'hFFFFF, 16'sd10, -16'sd300, -16'sd9000);
    send_sample(20'hFFFFF, -16'sd10, 16'sd300, 16'sd9000);
    write_reg(CFG_MEAS_VAR, 24'd0);
    send_sample(20'd2000, 16'sd10, 16'sd300, -16'sd9000);

    settings[0] = 24'd655;
    settings[1] = 24'd65536;
    settings[2] = 24'hFFFFFF;
    settings[3] = 24'd0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_GYRO_VAR, (ph < 4) ? settings[ph] : 24'($urandom));
      write_reg(CFG_MEAS_VAR, (ph < 4) ? settings[3 - ph] : 24'($urandom));
      if (ph == 3) begin
        no_gaps = 1;
        for (int i = 0; i < 30; i++) random_sample();
        no_gaps = 0;
      end
      for (int i = 0; i < 85; i++) random_sample();
    end

    write_reg(CFG_GYRO_VAR, GYRO_VAR_RST);
    while (tilt_sb.angle_q.size() != 0) @(negedge clk_i);
    stim_done = 1;
    repeat (200) @(negedge clk_i);
    if (tilt_sb.errors == 0 && tilt_sb.angle_q.size() == 0) begin
      $display("tilt_angle_kalman_filter test passed");
    end else begin
      $display("tilt_angle_kalman_filter test failed");
    end
    $finish;
  end
endmodule
